>>> design/sliding_window_point_average_unit_defines.svh
// Assertion macros shared by the sliding window point average unit.
`ifndef SLIDING_WINDOW_POINT_AVERAGE_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_POINT_AVERAGE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SWPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SWPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SWPA_ASSERT_SAME(lbl, ante, cons, msg)
`define SWPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/swpa_pkg.sv
// Shared constants and controller/datapath command and status types.
`default_nettype none
package swpa_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 7;
  localparam int MAX_WINDOW_DEF = 64;

  typedef struct packed {
    logic accept;
    logic rd;
    logic sub;
    logic add;
    logic div_start;
    logic load_out;
  } swpa_cmd_t;

  typedef struct packed {
    logic full;
    logic div_done;
    logic out_busy;
  } swpa_sts_t;

endpackage
`default_nettype wire

>>> design/swpa_if.sv
// Valid/ready channel interfaces for input points and averaged results.
`default_nettype none
interface swpa_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [swpa_pkg::DATA_W-1:0] x_sample;
  logic signed [swpa_pkg::DATA_W-1:0] y_sample;
  logic                              series_start;

  modport source (output valid, output x_sample, output y_sample, output series_start,
                  input ready);
  modport sink (input valid, input x_sample, input y_sample, input series_start,
                output ready);
endinterface

interface swpa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [swpa_pkg::DATA_W-1:0] x_average;
  logic signed [swpa_pkg::DATA_W-1:0] y_average;

  modport source (output valid, output x_average, output y_average, input ready);
  modport sink (input valid, input x_average, input y_average, output ready);
endinterface
`default_nettype wire

>>> design/sliding_window_point_average_unit.sv
// Top level of the sliding window point average unit.
//
//   Channel   Direction  Handshake        Carries
//   in_ch     input      valid/ready      x_sample, y_sample, series_start
//   out_ch    output     valid/ready      x_average, y_average
//   cfg_*     input      write enable     window_length
//
// An item with a result waits on the two-lane restoring divider, which produces
// one quotient bit per cycle. Synchronous reset clears the window and sets the
// window length to 1. A finished result waits in the output register; the next
// item is accepted meanwhile and its result is held in the divider until that
// register frees.
`default_nettype none
`include "sliding_window_point_average_unit_defines.svh"
module sliding_window_point_average_unit #(
  parameter int MAX_WINDOW = swpa_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  swpa_in_if.sink                         in_ch,
  swpa_out_if.source                      out_ch,
  input  wire logic                       cfg_wr_en,
  input  wire logic [swpa_pkg::CFG_W-1:0] cfg_wr_data
);
  import swpa_pkg::*;

  swpa_cmd_t cmd;
  swpa_sts_t sts;
  logic      in_ready;
  logic      out_valid;
  logic signed [DATA_W-1:0] out_x, out_y;

  swpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swpa_dpath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_x        (in_ch.x_sample),
    .in_y        (in_ch.y_sample),
    .in_start    (in_ch.series_start),
    .out_valid   (out_valid),
    .out_ready   (out_ch.ready),
    .out_x       (out_x),
    .out_y       (out_y)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.x_average = out_x;
  assign out_ch.y_average = out_y;

  `SWPA_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ready, !in_ready, "item accepted while busy")
  `SWPA_ASSERT_NEXT(a_load_shows_result, cmd.load_out, out_valid, "loaded result not presented")
  `SWPA_ASSERT_NEXT(a_div_restarts, cmd.div_start, !sts.div_done, "divider kept stale quotient")
  `SWPA_ASSERT_SAME(a_load_only_free, cmd.load_out, sts.div_done && !sts.out_busy, "result overwritten")

endmodule
`default_nettype wire

>>> design/swpa_div.sv
// Two-lane radix-2 restoring divider: signed sums divided by the window length.
`default_nettype none
module swpa_div #(
  parameter int SUM_W = 38,
  parameter int LEN_W = 7
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [SUM_W-1:0]           dividend_x,
  input  wire logic signed [SUM_W-1:0]           dividend_y,
  input  wire logic        [LEN_W-1:0]           divisor,
  output logic                                   done,
  output logic signed [swpa_pkg::DATA_W-1:0]     quot_x,
  output logic signed [swpa_pkg::DATA_W-1:0]     quot_y
);
  import swpa_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             running_r, running_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W-1:0] mag_r   [2];
  logic [SUM_W-1:0] mag_nxt [2];
  logic [LEN_W-1:0] rem_r   [2];
  logic [LEN_W-1:0] rem_nxt [2];
  logic             neg_r   [2];
  logic             neg_nxt [2];
  logic [SUM_W-1:0] dvd     [2];
  logic [LEN_W:0]   rem_sh  [2];
  logic             ge      [2];
  logic [SUM_W-1:0] q_full  [2];

  assign dvd[0] = dividend_x;
  assign dvd[1] = dividend_y;

  always_comb begin
    cnt_nxt     = cnt_r;
    running_nxt = running_r;
    done_nxt    = done_r;
    for (int i = 0; i < 2; i++) begin
      mag_nxt[i] = mag_r[i];
      rem_nxt[i] = rem_r[i];
      neg_nxt[i] = neg_r[i];
      rem_sh[i]  = {rem_r[i], mag_r[i][SUM_W-1]};
      ge[i]      = (rem_sh[i] >= {1'b0, divisor});
      q_full[i]  = neg_r[i] ? (~mag_r[i] + SUM_W'(1)) : mag_r[i];
    end
    if (start) begin
      running_nxt = 1'b1;
      done_nxt    = 1'b0;
      cnt_nxt     = CNT_W'(SUM_W);
      for (int i = 0; i < 2; i++) begin
        // Work on magnitudes; the most negative sum maps onto its unsigned value.
        neg_nxt[i] = dvd[i][SUM_W-1];
        mag_nxt[i] = dvd[i][SUM_W-1] ? (~dvd[i] + SUM_W'(1)) : dvd[i];
        rem_nxt[i] = '0;
      end
    end else if (running_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      for (int i = 0; i < 2; i++) begin
        rem_nxt[i] = ge[i] ? LEN_W'(rem_sh[i] - {1'b0, divisor}) : LEN_W'(rem_sh[i]);
        mag_nxt[i] = {mag_r[i][SUM_W-2:0], ge[i]};
      end
      if (cnt_r == CNT_W'(1)) begin
        running_nxt = 1'b0;
        done_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      running_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      running_r <= running_nxt;
      done_r    <= done_nxt;
    end
    for (int i = 0; i < 2; i++) begin
      mag_r[i] <= mag_nxt[i];
      rem_r[i] <= rem_nxt[i];
      neg_r[i] <= neg_nxt[i];
    end
  end

  assign done   = done_r;
  assign quot_x = q_full[0][DATA_W-1:0];
  assign quot_y = q_full[1][DATA_W-1:0];

endmodule
`default_nettype wire

>>> design/swpa_ctrl.sv
// Controller state machine sequencing one item through the datapath.
`default_nettype none
module swpa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire swpa_pkg::swpa_sts_t sts,
  output swpa_pkg::swpa_cmd_t      cmd
);
  import swpa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_SUB    = 6'b000100,
    S_ADD    = 6'b001000,
    S_DSTART = 6'b010000,
    S_DIV    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        // Fill count has already been advanced; a full window yields a result.
        state_nxt = sts.full ? S_DSTART : S_IDLE;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done && !sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/swpa_dpath.sv
// Datapath: window ring store, running sums, fill tracking, divider and result register.
`default_nettype none
module swpa_dpath #(
  parameter int MAX_WINDOW = swpa_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire swpa_pkg::swpa_cmd_t               cmd,
  output swpa_pkg::swpa_sts_t                    sts,
  input  wire logic                              cfg_wr_en,
  input  wire logic [swpa_pkg::CFG_W-1:0]        cfg_wr_data,
  input  wire logic signed [swpa_pkg::DATA_W-1:0] in_x,
  input  wire logic signed [swpa_pkg::DATA_W-1:0] in_y,
  input  wire logic                              in_start,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [swpa_pkg::DATA_W-1:0]     out_x,
  output logic signed [swpa_pkg::DATA_W-1:0]     out_y
);
  import swpa_pkg::*;

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = DATA_W + $clog2(MAX_WINDOW);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  logic [2*DATA_W-1:0] mem [MAX_WINDOW];
  logic [2*DATA_W-1:0] rd_data_r;

  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [LEN_W-1:0]        fill_r, fill_nxt;
  logic [PTR_W-1:0]        wpos_r, wpos_nxt;
  logic signed [SUM_W-1:0] xsum_r, xsum_nxt;
  logic signed [SUM_W-1:0] ysum_r, ysum_nxt;
  logic signed [DATA_W-1:0] x_r, y_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_x_r, out_y_r;

  logic [CMP_W-1:0]        cfg_ext;
  logic [PTR_W-1:0]        slot;
  logic [LEN_W-1:0]        slot_inc;
  logic                    full;
  logic signed [SUM_W-1:0] x_ext, y_ext, old_x_ext, old_y_ext;
  logic                    div_done;
  logic signed [DATA_W-1:0] quot_x, quot_y;

  assign cfg_ext   = CMP_W'(cfg_wr_data);
  assign slot      = (LEN_W'(wpos_r) >= len_r) ? '0 : wpos_r;
  assign slot_inc  = LEN_W'(slot) + LEN_W'(1);
  assign full      = (fill_r >= len_r);
  assign x_ext     = {{(SUM_W-DATA_W){x_r[DATA_W-1]}}, x_r};
  assign y_ext     = {{(SUM_W-DATA_W){y_r[DATA_W-1]}}, y_r};
  assign old_x_ext = {{(SUM_W-DATA_W){rd_data_r[2*DATA_W-1]}}, rd_data_r[2*DATA_W-1:DATA_W]};
  assign old_y_ext = {{(SUM_W-DATA_W){rd_data_r[DATA_W-1]}}, rd_data_r[DATA_W-1:0]};

  always_comb begin
    len_nxt       = len_r;
    fill_nxt      = fill_r;
    wpos_nxt      = wpos_r;
    xsum_nxt      = xsum_r;
    ysum_nxt      = ysum_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
    if (cfg_wr_en) begin
      // A zero length passes points through; lengths past the store saturate.
      if (cfg_wr_data == '0) begin
        len_nxt = LEN_W'(1);
      end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
        len_nxt = LEN_W'(MAX_WINDOW);
      end else begin
        len_nxt = LEN_W'(cfg_ext);
      end
      fill_nxt = '0;
      wpos_nxt = '0;
      xsum_nxt = '0;
      ysum_nxt = '0;
    end else if (cmd.accept && in_start) begin
      fill_nxt = '0;
      wpos_nxt = '0;
      xsum_nxt = '0;
      ysum_nxt = '0;
    end else if (cmd.sub) begin
      if (full) begin
        xsum_nxt = xsum_r - old_x_ext;
        ysum_nxt = ysum_r - old_y_ext;
      end else begin
        fill_nxt = fill_r + LEN_W'(1);
      end
      wpos_nxt = (slot_inc >= len_r) ? '0 : PTR_W'(slot_inc);
    end else if (cmd.add) begin
      xsum_nxt = xsum_r + x_ext;
      ysum_nxt = ysum_r + y_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LEN_W'(1);
      fill_r      <= '0;
      wpos_r      <= '0;
      xsum_r      <= '0;
      ysum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      fill_r      <= fill_nxt;
      wpos_r      <= wpos_nxt;
      xsum_r      <= xsum_nxt;
      ysum_r      <= ysum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r <= in_x;
      y_r <= in_y;
    end
    if (cmd.load_out) begin
      out_x_r <= quot_x;
      out_y_r <= quot_y;
    end
  end

  // The entry at the slot is read before it is overwritten with the new point.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[slot];
    end
    if (cmd.sub) begin
      mem[slot] <= {x_r, y_r};
    end
  end

  swpa_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.div_start),
    .dividend_x (xsum_r),
    .dividend_y (ysum_r),
    .divisor    (len_r),
    .done       (div_done),
    .quot_x     (quot_x),
    .quot_y     (quot_y)
  );

  assign sts.full     = full;
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;

endmodule
`default_nettype wire
